>>> rtl/pid_filtered_derivative_core_assert.svh
// Assertion macros for the filtered-derivative PID core checker.
// No dependencies; included by the checker file.
`ifndef PID_FILTERED_DERIVATIVE_CORE_ASSERT_SVH
`define PID_FILTERED_DERIVATIVE_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define PIDFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pidfd assertion failed");

// next-cycle implication, disabled in reset
`define PIDFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pidfd assertion failed");

// same-cycle implication, also checked in reset
`define PIDFD_ASSERT_ALL(label, clk, ante, cons) \
	label: assert property (@(posedge clk) (ante) |-> (cons)) \
		else $error("pidfd assertion failed");

`endif

>>> rtl/pidfd_pkg.sv
// Package for the filtered-derivative PID core: widths, register indexes,
// payload and stage structs. No dependencies.
`default_nettype none

package pidfd_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int DEV_W      = 17;
	localparam int GAIN_W     = 24;
	localparam int POLE_W     = 16;
	localparam int ACC_W      = 32;
	localparam int PROD_W     = GAIN_W + DEV_W;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_POLE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 8'd3;

	typedef struct packed {
		logic signed [GAIN_W-1:0] prop;
		logic signed [GAIN_W-1:0] integ;
		logic        [POLE_W-1:0] pole;
		logic signed [GAIN_W-1:0] deriv;
	} gains_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] target;
		logic signed [SAMPLE_W-1:0] measured;
		logic                       restart;
	} sample_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] prop_prod;
		logic signed [ACC_W-1:0]  deriv;
		logic signed [ACC_W-1:0]  integ;
		logic signed [DEV_W-1:0]  dev;
		logic                     clip;
	} stage_t;

endpackage

`default_nettype wire

>>> rtl/pidfd_if.sv
// Channel interfaces of the filtered-derivative PID core: sample input,
// result output and configuration write. Depends on pidfd_pkg.
`default_nettype none

interface pidfd_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pidfd_pkg::SAMPLE_W-1:0] target;
	logic signed [pidfd_pkg::SAMPLE_W-1:0] measured;
	logic                                 restart;

	modport source (output valid, output target, output measured, output restart,
		input ready);
	modport sink (input valid, input target, input measured, input restart,
		output ready);
endinterface

interface pidfd_result_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [pidfd_pkg::SAMPLE_W-1:0] drive;
	logic signed [pidfd_pkg::DEV_W-1:0]    deviation;
	logic                                 clipped;

	modport source (output valid, output drive, output deviation, output clipped,
		input ready);
	modport sink (input valid, input drive, input deviation, input clipped,
		output ready);
endinterface

interface pidfd_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [pidfd_pkg::CFG_IDX_W-1:0]    index;
	logic [pidfd_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/pidfd_update.sv
// State update stage: error, filtered derivative and integral with
// saturation; holds last measurement and both accumulators. Uses pidfd_pkg.
`default_nettype none

module pidfd_update (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pidfd_pkg::gains_t  gains,
	input  wire pidfd_pkg::sample_t smp,
	input  wire logic              step_en,
	output pidfd_pkg::stage_t       stage
);
	import pidfd_pkg::*;

	function automatic logic [ACC_W:0] sat_acc(input logic signed [ACC_W+9:0] v);
		logic hi_ok;
		hi_ok = (&v[ACC_W+9:ACC_W-1]) || !(|v[ACC_W+9:ACC_W-1]);
		if (hi_ok) begin
			sat_acc = {1'b0, v[ACC_W-1:0]};
		end else if (v[ACC_W+9]) begin
			sat_acc = {1'b1, 1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			sat_acc = {1'b1, 1'b0, {(ACC_W-1){1'b1}}};
		end
	endfunction

	logic signed [SAMPLE_W-1:0]  last_q;
	logic signed [ACC_W-1:0]     deriv_q;
	logic signed [ACC_W-1:0]     integ_q;
	logic signed [SAMPLE_W-1:0]  last_use;
	logic signed [ACC_W-1:0]     deriv_use;
	logic signed [ACC_W-1:0]     integ_use;
	logic signed [DEV_W-1:0]     dev;
	logic signed [DEV_W-1:0]     dm;
	logic signed [ACC_W+POLE_W:0] pole_prod;
	logic signed [ACC_W-1:0]     pole_sh;
	logic signed [PROD_W-1:0]    dgain_prod;
	logic signed [PROD_W-1:0]    igain_prod;
	logic signed [PROD_W-1:0]    pgain_prod;
	logic signed [ACC_W+9:0]     nd;
	logic signed [ACC_W+9:0]     ni;
	logic        [ACC_W:0]       nd_sat;
	logic        [ACC_W:0]       ni_sat;

	always_comb begin
		if (smp.restart) begin
			last_use  = '0;
			deriv_use = '0;
			integ_use = '0;
		end else begin
			last_use  = last_q;
			deriv_use = deriv_q;
			integ_use = integ_q;
		end
	end

	assign dev = {smp.target[SAMPLE_W-1], smp.target}
		- {smp.measured[SAMPLE_W-1], smp.measured};
	assign dm = {smp.measured[SAMPLE_W-1], smp.measured}
		- {last_use[SAMPLE_W-1], last_use};

	// floor shift of pole * acc; |result| <= |acc| since pole < 1
	assign pole_prod  = $signed({1'b0, gains.pole}) * deriv_use;
	assign pole_sh    = pole_prod[ACC_W+POLE_W-1:POLE_W];
	assign dgain_prod = gains.deriv * dm;
	assign igain_prod = gains.integ * dev;
	assign pgain_prod = gains.prop * dev;

	assign nd = {{10{pole_sh[ACC_W-1]}}, pole_sh} + {dgain_prod[PROD_W-1], dgain_prod};
	assign ni = {{10{integ_use[ACC_W-1]}}, integ_use} + {igain_prod[PROD_W-1], igain_prod};

	assign nd_sat = sat_acc(nd);
	assign ni_sat = sat_acc(ni);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			deriv_q <= '0;
			integ_q <= '0;
		end else if (step_en) begin
			last_q  <= smp.measured;
			deriv_q <= nd_sat[ACC_W-1:0];
			integ_q <= ni_sat[ACC_W-1:0];
		end
	end

	always_comb begin
		stage.prop_prod = pgain_prod;
		stage.deriv     = nd_sat[ACC_W-1:0];
		stage.integ     = ni_sat[ACC_W-1:0];
		stage.dev       = dev;
		stage.clip      = nd_sat[ACC_W] | ni_sat[ACC_W];
	end

endmodule

`default_nettype wire

>>> rtl/pidfd_out.sv
// Output stage: sums the terms, rounds half up and saturates to 16 bits.
// Uses pidfd_pkg.
`default_nettype none

module pidfd_out (
	input  wire pidfd_pkg::stage_t                 st,
	output logic signed [pidfd_pkg::SAMPLE_W-1:0] drive,
	output logic                                 clipped
);
	import pidfd_pkg::*;

	localparam int SUM_W = PROD_W + 2;
	localparam int Y_W   = SUM_W - 16;

	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] rnd;
	logic signed [Y_W-1:0]   y;
	logic                    fits;

	assign sum = {{2{st.prop_prod[PROD_W-1]}}, st.prop_prod}
		+ {{(SUM_W-ACC_W){st.deriv[ACC_W-1]}}, st.deriv}
		+ {{(SUM_W-ACC_W){st.integ[ACC_W-1]}}, st.integ};
	assign rnd  = sum + SUM_W'(32768);
	assign y    = rnd[SUM_W-1:16];
	assign fits = (&y[Y_W-1:SAMPLE_W-1]) || !(|y[Y_W-1:SAMPLE_W-1]);

	always_comb begin
		if (fits) begin
			drive = y[SAMPLE_W-1:0];
		end else if (y[Y_W-1]) begin
			drive = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			drive = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
		clipped = st.clip | !fits;
	end

endmodule

`default_nettype wire

>>> rtl/pid_filtered_derivative_core.sv
// A sample transaction reaches result valid through the input register, the
// state update register and the result register. Throughput: one sample per
// cycle while the result side accepts; the accumulator feedback closes inside
// the update stage. Stalls on the result side fill the empty stages before
// ready drops. Reset (arst_n low, asynchronous) clears gains, last measurement,
// both accumulators and all valid flags.
`default_nettype none

module pid_filtered_derivative_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	pidfd_sample_if.sink    sample,
	pidfd_result_if.source  result,
	pidfd_cfg_if.sink       cfg
);
	import pidfd_pkg::*;

	gains_t  gains_q;
	logic    v_s1;
	sample_t smp_s1;
	logic    v_s2;
	stage_t  st_s2;
	stage_t  stage;
	logic    v_q;
	logic signed [SAMPLE_W-1:0] drive_q;
	logic signed [DEV_W-1:0]    dev_q;
	logic                       clip_q;
	logic signed [SAMPLE_W-1:0] drive;
	logic                       clipped;
	logic    adv1;
	logic    adv2;
	logic    step_en;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PROP_GAIN:  gains_q.prop  <= cfg.data[GAIN_W-1:0];
				REG_INTEG_GAIN: gains_q.integ <= cfg.data[GAIN_W-1:0];
				REG_DERIV_POLE: gains_q.pole  <= cfg.data[POLE_W-1:0];
				REG_DERIV_GAIN: gains_q.deriv <= cfg.data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv2         = !v_q || result.ready;
	assign adv1         = !v_s2 || adv2;
	assign sample.ready = !v_s1 || adv1;
	assign step_en      = v_s1 && adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_q  <= 1'b0;
		end else begin
			if (sample.ready) begin
				v_s1 <= sample.valid;
			end
			if (adv1) begin
				v_s2 <= v_s1;
			end
			if (adv2) begin
				v_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			smp_s1.target   <= sample.target;
			smp_s1.measured <= sample.measured;
			smp_s1.restart  <= sample.restart;
		end
		if (step_en) begin
			st_s2 <= stage;
		end
		if (v_s2 && adv2) begin
			drive_q <= drive;
			dev_q   <= st_s2.dev;
			clip_q  <= clipped;
		end
	end

	pidfd_update u_update (
		.clk     (clk),
		.arst_n  (arst_n),
		.gains   (gains_q),
		.smp     (smp_s1),
		.step_en (step_en),
		.stage   (stage)
	);

	pidfd_out u_out (
		.st      (st_s2),
		.drive   (drive),
		.clipped (clipped)
	);

	assign result.valid     = v_q;
	assign result.drive     = drive_q;
	assign result.deviation = dev_q;
	assign result.clipped   = clip_q;

endmodule

`default_nettype wire

>>> rtl/pidfd_checker.sv
// Port-level checker for the filtered-derivative PID core, bound to the top.
// Depends on pidfd_pkg and pid_filtered_derivative_core_assert.svh.
`default_nettype none

`include "pid_filtered_derivative_core_assert.svh"

module pidfd_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 sample_valid,
	input wire logic                                 sample_ready,
	input wire logic                                 result_valid,
	input wire logic                                 result_ready,
	input wire logic signed [pidfd_pkg::SAMPLE_W-1:0] result_drive,
	input wire logic signed [pidfd_pkg::DEV_W-1:0]    result_deviation,
	input wire logic                                 result_clipped
);
	import pidfd_pkg::*;

	`PIDFD_ASSERT_ALL(a_reset_empty, clk, !arst_n, !result_valid)

	`PIDFD_ASSERT_IMP(a_ready_when_drained, clk, arst_n, !result_valid, sample_ready)

	`PIDFD_ASSERT_IMP(a_latency, clk, arst_n,
		(sample_valid && sample_ready) ##1 result_ready ##1 result_ready,
		##1 result_valid)

	`PIDFD_ASSERT_NXT(a_result_hold, clk, arst_n, result_valid && !result_ready,
		result_valid && $stable(result_drive) && $stable(result_deviation) && $stable(result_clipped))

endmodule

bind pid_filtered_derivative_core pidfd_checker u_pidfd_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.sample_valid     (sample.valid),
	.sample_ready     (sample.ready),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.result_drive     (result.drive),
	.result_deviation (result.deviation),
	.result_clipped   (result.clipped)
);

`default_nettype wire

>>> tb/sv/tb_pid_filtered_derivative_core.sv
// Self-checking testbench for pid_filtered_derivative_core: directed and random
// sample streams checked against an in-bench fixed-point PID predictor.
// Depends on pidfd_pkg, the pidfd channel interfaces and the core RTL.
`default_nettype none

module tb_pid_filtered_derivative_core;
	timeunit 1ns;
	timeprecision 1ps;

	import pidfd_pkg::*;

	localparam int     PIPE_DEPTH  = 3;
	localparam int     CYCLE_LIMIT = 200000;
	localparam longint ACC_MIN     = -(64'sd1 <<< 31);
	localparam longint ACC_MAX     = (64'sd1 <<< 31) - 1;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] drive;
		logic signed [DEV_W-1:0]    deviation;
		logic                       clipped;
	} pid_out_t;

	logic clk = 1'b0;
	logic arst_n;

	pidfd_sample_if smp_ch();
	pidfd_result_if res_ch();
	pidfd_cfg_if    cfg_ch();

	pid_filtered_derivative_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (smp_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #10 clk = ~clk;

	// predictor state
	gains_t                     coeffs     = '0;
	logic signed [SAMPLE_W-1:0] prev_meas  = '0;
	logic signed [ACC_W-1:0]    deriv_term = '0;
	logic signed [ACC_W-1:0]    integ_term = '0;
	pid_out_t                   pending_outputs[$];

	int  mismatches   = 0;
	int  cycle_count  = 0;
	bit  steady       = 1'b0;
	int  stall_request = 0;
	int  stall_left   = 0;
	int  setpoint     = 0;
	int  plant_level  = 0;

	int gain_corners[5] = '{-8388608, 8388607, 0, 1, -1};
	int pole_corners[4] = '{0, 65535, 1, 32768};

	function automatic longint saturate(input longint v, input longint lo,
		input longint hi, inout bit hit);
		if (v < lo) begin
			hit = 1'b1;
			return lo;
		end
		if (v > hi) begin
			hit = 1'b1;
			return hi;
		end
		return v;
	endfunction

	function automatic pid_out_t control_step(input sample_t s);
		longint   err, dmeas, nd, ni, total, y;
		bit       hit;
		pid_out_t out;
		hit = 1'b0;
		if (s.restart) begin
			prev_meas  = '0;
			deriv_term = '0;
			integ_term = '0;
		end
		err   = longint'($signed(s.target)) - longint'($signed(s.measured));
		dmeas = longint'($signed(s.measured)) - longint'(prev_meas);
		prev_meas = s.measured;
		nd = ((longint'(coeffs.pole) * longint'(deriv_term)) >>> 16)
			+ longint'($signed(coeffs.deriv)) * dmeas;
		deriv_term = ACC_W'(saturate(nd, ACC_MIN, ACC_MAX, hit));
		ni = longint'(integ_term) + longint'($signed(coeffs.integ)) * err;
		integ_term = ACC_W'(saturate(ni, ACC_MIN, ACC_MAX, hit));
		total = longint'($signed(coeffs.prop)) * err + longint'(integ_term)
			+ longint'(deriv_term);
		y = (total + 32768) >>> 16;
		y = saturate(y, -32768, 32767, hit);
		out.drive     = SAMPLE_W'(y);
		out.deviation = DEV_W'(err);
		out.clipped   = hit;
		return out;
	endfunction

	function automatic sample_t sample_of(input int t, input int m, input bit r);
		sample_t s;
		s.target   = SAMPLE_W'(t);
		s.measured = SAMPLE_W'(m);
		s.restart  = r;
		return s;
	endfunction

	// all driving tasks are entered and left at a falling edge
	task automatic send_sample(input sample_t s);
		while (!steady && $urandom_range(99) < 23) begin
			smp_ch.valid <= 1'b0;
			@(negedge clk);
		end
		smp_ch.valid    <= 1'b1;
		smp_ch.target   <= s.target;
		smp_ch.measured <= s.measured;
		smp_ch.restart  <= s.restart;
		@(posedge clk);
		while (!smp_ch.ready) @(posedge clk);
		pending_outputs.insert(pending_outputs.size(), control_step(s));
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_PROP_GAIN:  coeffs.prop  = value;
			REG_INTEG_GAIN: coeffs.integ = value;
			REG_DERIV_POLE: coeffs.pole  = value[POLE_W-1:0];
			REG_DERIV_GAIN: coeffs.deriv = value;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_gains(input int prop, input int integ, input int pole,
		input int deriv);
		write_reg(REG_PROP_GAIN, CFG_DATA_W'(prop));
		write_reg(REG_INTEG_GAIN, CFG_DATA_W'(integ));
		write_reg(REG_DERIV_POLE, CFG_DATA_W'(pole));
		write_reg(REG_DERIV_GAIN, CFG_DATA_W'(deriv));
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_idle();
		smp_ch.valid <= 1'b0;
		while (pending_outputs.size() != 0) @(negedge clk);
		repeat (PIPE_DEPTH + 2) @(negedge clk);
	endtask

	// mostly a plant tracking its setpoint, with a share of unrelated noise
	task automatic send_random_items(input int count, input int noise_pct);
		sample_t s;
		int      pos;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < noise_pct) begin
				s.target   = SAMPLE_W'($urandom);
				s.measured = SAMPLE_W'($urandom);
				s.restart  = ($urandom_range(9) == 0);
			end else begin
				if ($urandom_range(19) == 0)
					setpoint = int'($urandom_range(0, 65535)) - 32768;
				pos = plant_level + (setpoint - plant_level) / 8
					+ int'($urandom_range(0, 128)) - 64;
				if (pos > 32767) pos = 32767;
				if (pos < -32768) pos = -32768;
				plant_level = pos;
				s = sample_of(setpoint, pos, $urandom_range(49) == 0);
			end
			send_sample(s);
		end
	endtask

	task automatic pick_gains(input int kind);
		int gp, gi, gd, gr;
		if ($urandom_range(2) == 0)
			write_reg(CFG_IDX_W'($urandom_range(4, 255)), CFG_DATA_W'($urandom));
		case (kind)
			0: begin
				gp = int'($urandom_range(0, 1 << 18)) - (1 << 16);
				gi = ($urandom_range(3) == 0) ? 0 : int'($urandom_range(0, 4096));
				gr = $urandom_range(32768, 65535);
				gd = -int'($urandom_range(0, 1 << 20));
			end
			1: begin
				gp = $urandom;
				gi = $urandom;
				gr = $urandom;
				gd = $urandom;
			end
			default: begin
				gp = gain_corners[$urandom_range(4)];
				gi = gain_corners[$urandom_range(4)];
				gr = pole_corners[$urandom_range(3)];
				gd = gain_corners[$urandom_range(4)];
			end
		endcase
		set_gains(gp, gi, gr, gd);
	endtask

	task automatic test_zero_gains();
		send_sample(sample_of(32767, -32768, 1'b0));
		send_sample(sample_of(-32768, 32767, 1'b0));
		send_sample(sample_of(0, 0, 1'b1));
	endtask

	task automatic test_proportional();
		wait_idle();
		set_gains(32'h008000, 0, 0, 0);
		send_sample(sample_of(1, 0, 1'b0));
		send_sample(sample_of(-1, 0, 1'b0));
		send_sample(sample_of(3, 0, 1'b0));
		wait_idle();
		set_gains(8388607, 0, 0, 0);
		send_sample(sample_of(32767, -32768, 1'b0));
		send_sample(sample_of(-32768, 32767, 1'b0));
		wait_idle();
		set_gains(-8388608, 0, 0, 0);
		send_sample(sample_of(1, 0, 1'b0));
		send_sample(sample_of(32767, -32768, 1'b0));
	endtask

	task automatic test_integral_saturation();
		wait_idle();
		set_gains(0, 8388607, 0, 0);
		send_sample(sample_of(32767, -32768, 1'b1));
		send_sample(sample_of(0, 0, 1'b0));
		send_sample(sample_of(-32768, 32767, 1'b0));
		send_sample(sample_of(5, 5, 1'b1));
	endtask

	task automatic test_derivative_filter();
		wait_idle();
		set_gains(0, 0, 32'hFFFFFF, -8388608);
		send_sample(sample_of(0, -32768, 1'b1));
		send_sample(sample_of(0, 32767, 1'b0));
		send_sample(sample_of(0, 32767, 1'b0));
		send_sample(sample_of(0, 32767, 1'b0));
		wait_idle();
		set_gains(0, 0, 32'hAB0000, 32'h000100);
		send_sample(sample_of(0, 100, 1'b0));
		send_sample(sample_of(0, -100, 1'b0));
	endtask

	task automatic test_ignored_indexes();
		wait_idle();
		write_reg(8'd4, 24'hFFFFFF);
		write_reg(8'hFF, 24'h123456);
		write_reg(8'h80, 24'h800000);
		cfg_ch.valid <= 1'b0;
		send_sample(sample_of(1000, -1000, 1'b0));
		send_sample(sample_of(-1000, 1000, 1'b0));
	endtask

	task automatic test_steady_stream();
		wait_idle();
		pick_gains(0);
		steady = 1'b1;
		send_random_items(150, 10);
		steady = 1'b0;
	endtask

	task automatic test_output_backpressure();
		wait_idle();
		pick_gains(0);
		steady = 1'b1;
		@(posedge clk);
		stall_request = 80;
		@(negedge clk);
		send_random_items(60, 10);
		steady = 1'b0;
	endtask

	task automatic test_random_phases();
		for (int phase = 0; phase < 10; phase++) begin
			wait_idle();
			pick_gains(phase % 3);
			send_random_items(132, 20);
		end
	endtask

	// result sink: random stalls outside steady phases, plus a long hold-off on request
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left == 0 && stall_request > 0) begin
				stall_left    = stall_request;
				stall_request = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= steady || $urandom_range(99) >= 23;
			end
		end
	end

	always @(posedge clk) begin : result_check
		pid_out_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (pending_outputs.size() == 0) begin
				$error("result transaction with no sample outstanding");
				mismatches++;
			end else begin
				want = pending_outputs.pop_front();
				if (res_ch.drive !== want.drive) begin
					$error("drive: expected %0d, got %0d", want.drive, res_ch.drive);
					mismatches++;
				end
				if (res_ch.deviation !== want.deviation) begin
					$error("deviation: expected %0d, got %0d", want.deviation,
						res_ch.deviation);
					mismatches++;
				end
				if (res_ch.clipped !== want.clipped) begin
					$error("clipped: expected %0d, got %0d", want.clipped,
						res_ch.clipped);
					mismatches++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_pid_filtered_derivative_core: FAIL");
		$finish;
	end

	initial begin
		arst_n          <= 1'b0;
		smp_ch.valid    <= 1'b0;
		smp_ch.target   <= '0;
		smp_ch.measured <= '0;
		smp_ch.restart  <= 1'b0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= '0;
		cfg_ch.data     <= '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_zero_gains();
		test_proportional();
		test_integral_saturation();
		test_derivative_filter();
		test_ignored_indexes();
		test_steady_stream();
		test_output_backpressure();
		test_random_phases();
		wait_idle();
		if (mismatches == 0)
			$display("tb_pid_filtered_derivative_core: PASS");
		else
			$display("tb_pid_filtered_derivative_core: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

>>> pid_filtered_derivative_core.f
+incdir+rtl
rtl/pidfd_pkg.sv
rtl/pidfd_if.sv
rtl/pidfd_update.sv
rtl/pidfd_out.sv
rtl/pid_filtered_derivative_core.sv
rtl/pidfd_checker.sv
tb/sv/tb_pid_filtered_derivative_core.sv
